### hdl/gses_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gses_pkg
// Shared widths, constants and types of the greyscale Sobel edge stream.
// ----------------------------------------------------------------------------
package gses_pkg;

   localparam int PIX_W = 8;            // color and grey samples
   localparam int DIM_W = 11;           // frame size registers
   localparam int POS_W = 10;           // row and column positions
   localparam int PROD_W = 24;          // weighted sum before the grey shift
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [DIM_W-1:0] MAX_WIDTH = 11'd1024;
   localparam logic [DIM_W-1:0] MAX_HEIGHT = 11'd1024;
   localparam logic [DIM_W-1:0] MIN_DIM = 11'd3;
   localparam logic [DIM_W-1:0] WIDTH_RESET = 11'd640;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;

   // Q16 luma weights, summing to 65536
   localparam logic [16:0] WEIGHT_RED = 17'd19595;
   localparam logic [16:0] WEIGHT_GREEN = 17'd38470;
   localparam logic [16:0] WEIGHT_BLUE = 17'd7471;

   localparam logic [PIX_W-1:0] MAG_MAX = 8'd255;

   // register index codes
   localparam logic REG_FRAME_WIDTH = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   // one complete 3x3 neighborhood, ready for the gradient
   typedef struct packed {
      logic [PIX_W-1:0] tl;
      logic [PIX_W-1:0] tc;
      logic [PIX_W-1:0] tr;
      logic [PIX_W-1:0] ml;
      logic [PIX_W-1:0] mr;
      logic [PIX_W-1:0] bl;
      logic [PIX_W-1:0] bc;
      logic [PIX_W-1:0] br;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic last;
   } window_type;

endpackage

### hdl/gses_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gses_front
// Pixel intake: position tracking, grey conversion, line stores and the
// 3x3 window. Pushes one window per interior pixel into the queue.
// ----------------------------------------------------------------------------
module gses_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [gses_pkg::PIX_W-1:0] req_blue,
   input  logic [gses_pkg::PIX_W-1:0] req_green,
   input  logic [gses_pkg::PIX_W-1:0] req_red,
   input  logic                       req_start_of_frame,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [gses_pkg::DIM_W-1:0] csr_data,
   output logic                       q_push,
   input  logic                       q_full,
   output gses_pkg::window_type       q_item
);
   import gses_pkg::*;

   logic [DIM_W-1:0] width_ff, height_ff;
   logic [DIM_W-1:0] w_eff, h_eff;
   logic [POS_W-1:0] row_ff, col_ff, row_in, col_in;
   logic [POS_W-1:0] r_raw, c_raw, r_cur, c_cur;
   logic [DIM_W-1:0] c_inc, r_inc;

   logic accept, a_move, fwd;
   logic a_valid_ff, a_valid_in;
   logic a_emit_ff, a_last_ff;
   logic [POS_W-1:0] a_row_ff, a_col_ff;
   logic [PROD_W-1:0] a_pr_ff, a_pg_ff, a_pb_ff;
   logic [PROD_W-1:0] wsum;
   logic [PIX_W-1:0] a_top_ff, a_mid_ff, grey;

   logic [PIX_W-1:0] upper_mem [0:MAX_WIDTH-1];
   logic [PIX_W-1:0] middle_mem [0:MAX_WIDTH-1];
   logic [PIX_W-1:0] win_ff [0:5];

   // ---- configuration ----
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         if (csr_index == REG_FRAME_WIDTH) width_ff <= csr_data;
         if (csr_index == REG_FRAME_HEIGHT) height_ff <= csr_data;
      end
   end

   assign w_eff = (width_ff < MIN_DIM) ? MIN_DIM :
                  (width_ff > MAX_WIDTH) ? MAX_WIDTH : width_ff;
   assign h_eff = (height_ff < MIN_DIM) ? MIN_DIM :
                  (height_ff > MAX_HEIGHT) ? MAX_HEIGHT : height_ff;

   // ---- position of the incoming beat ----
   assign r_raw = req_start_of_frame ? '0 : row_ff;
   assign c_raw = req_start_of_frame ? '0 : col_ff;
   // a shrunken frame pins the counter to its last column / row
   assign c_cur = ({1'b0, c_raw} >= w_eff) ? POS_W'(w_eff - 1'b1) : c_raw;
   assign r_cur = ({1'b0, r_raw} >= h_eff) ? POS_W'(h_eff - 1'b1) : r_raw;
   assign c_inc = {1'b0, c_cur} + 1'b1;
   assign r_inc = {1'b0, r_cur} + 1'b1;

   always_comb begin
      col_in = c_inc[POS_W-1:0];
      row_in = r_cur;
      if (c_inc >= w_eff) begin
         col_in = '0;
         row_in = (r_inc >= h_eff) ? '0 : r_inc[POS_W-1:0];
      end
   end

   // ---- stage A handshake ----
   assign a_move = a_valid_ff && (!a_emit_ff || !q_full);
   assign req_ready = !a_valid_ff || a_move;
   assign accept = req_valid && req_ready;
   assign a_valid_in = accept || (a_valid_ff && !a_move);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         if (accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_row_ff <= r_cur;
         a_col_ff <= c_cur;
         a_emit_ff <= (r_cur >= POS_W'(2)) && (c_cur >= POS_W'(2));
         a_last_ff <= ({1'b0, r_cur} == h_eff - 1'b1) && ({1'b0, c_cur} == w_eff - 1'b1);
         a_pr_ff <= PROD_W'(WEIGHT_RED) * PROD_W'(req_red);
         a_pg_ff <= PROD_W'(WEIGHT_GREEN) * PROD_W'(req_green);
         a_pb_ff <= PROD_W'(WEIGHT_BLUE) * PROD_W'(req_blue);
      end
   end

   assign wsum = a_pr_ff + a_pg_ff + a_pb_ff;
   assign grey = wsum[PROD_W-1:PROD_W-PIX_W];

   // same column read while it is being written (restart on the same pixel)
   assign fwd = a_move && (a_col_ff == c_cur);

   // ---- line stores ----
   always_ff @(posedge clock) begin
      if (a_move) begin
         upper_mem[a_col_ff] <= a_mid_ff;
         middle_mem[a_col_ff] <= grey;
      end
      if (accept) begin
         a_top_ff <= fwd ? a_mid_ff : upper_mem[c_cur];
         a_mid_ff <= fwd ? grey : middle_mem[c_cur];
      end
   end

   // ---- 3x3 window: two previous columns ----
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) win_ff[i] <= '0;
      end else if (a_move) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= a_top_ff;
         win_ff[4] <= a_mid_ff;
         win_ff[5] <= grey;
      end
   end

   assign q_push = a_move && a_emit_ff;

   always_comb begin
      q_item.tl = win_ff[0];
      q_item.ml = win_ff[1];
      q_item.bl = win_ff[2];
      q_item.tc = win_ff[3];
      q_item.bc = win_ff[5];
      q_item.tr = a_top_ff;
      q_item.mr = a_mid_ff;
      q_item.br = grey;
      q_item.row = a_row_ff - 1'b1;
      q_item.col = a_col_ff - 1'b1;
      q_item.last = a_last_ff;
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !a_move |=> a_valid_ff && $stable(a_col_ff) && $stable(a_row_ff))
      else $error("stage A dropped or changed a held beat");
   a_load: assert property (@(posedge clock) disable iff (reset)
      accept |=> a_valid_ff)
      else $error("accepted beat did not reach stage A");

endmodule

### hdl/gses_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gses_queue
// Small FIFO of complete windows between the front end and the gradient unit.
// ----------------------------------------------------------------------------
module gses_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  gses_pkg::window_type push_item,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output gses_pkg::window_type head
);
   import gses_pkg::*;

   window_type mem [0:QUEUE_DEPTH-1];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head = mem[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (!push && pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_item;
   end

   q_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");
   q_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");
   q_ptr_track: assert property (@(posedge clock) disable iff (reset)
      QCNT_W'(QPTR_W'(wr_ptr_ff - rd_ptr_ff)) == (full ? '0 : count_ff))
      else $error("queue pointers and count disagree");

endmodule

### hdl/gses_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gses_back
// Sobel gradient |Gx|+|Gy| with saturation, into the result register.
// ----------------------------------------------------------------------------
module gses_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_not_empty,
   input  gses_pkg::window_type       q_head,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [gses_pkg::PIX_W-1:0] rsp_magnitude,
   output logic [gses_pkg::POS_W-1:0] rsp_out_row,
   output logic [gses_pkg::POS_W-1:0] rsp_out_col,
   output logic                       rsp_last_of_frame
);
   import gses_pkg::*;

   localparam int SUM_W = PIX_W + 2;   // a + 2b + c
   localparam int DIF_W = SUM_W + 1;
   localparam int MAG_W = DIF_W;

   logic out_valid_ff;
   logic [PIX_W-1:0] mag_ff;
   logic [POS_W-1:0] row_ff, col_ff;
   logic last_ff;

   logic [SUM_W-1:0] right, left, upper, lower;
   logic signed [DIF_W-1:0] gx, gy;
   logic [SUM_W-1:0] ax, ay;
   logic [MAG_W-1:0] mag;
   logic [PIX_W-1:0] mag_sat;

   assign right = SUM_W'(q_head.tr) + {q_head.mr, 1'b0} + SUM_W'(q_head.br);
   assign left  = SUM_W'(q_head.tl) + {q_head.ml, 1'b0} + SUM_W'(q_head.bl);
   assign upper = SUM_W'(q_head.tl) + {q_head.tc, 1'b0} + SUM_W'(q_head.tr);
   assign lower = SUM_W'(q_head.bl) + {q_head.bc, 1'b0} + SUM_W'(q_head.br);

   assign gx = $signed({1'b0, right}) - $signed({1'b0, left});
   assign gy = $signed({1'b0, upper}) - $signed({1'b0, lower});
   assign ax = gx[DIF_W-1] ? SUM_W'(-gx) : SUM_W'(gx);
   assign ay = gy[DIF_W-1] ? SUM_W'(-gy) : SUM_W'(gy);
   assign mag = {1'b0, ax} + {1'b0, ay};
   assign mag_sat = (mag > MAG_W'(MAG_MAX)) ? MAG_MAX : mag[PIX_W-1:0];

   assign q_pop = q_not_empty && (!out_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (q_pop) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         mag_ff <= mag_sat;
         row_ff <= q_head.row;
         col_ff <= q_head.col;
         last_ff <= q_head.last;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_magnitude = mag_ff;
   assign rsp_out_row = row_ff;
   assign rsp_out_col = col_ff;
   assign rsp_last_of_frame = last_ff;

endmodule

### hdl/greyscale_sobel_edge_stream_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greyscale_sobel_edge_stream_unit
// Streaming 3x3 Sobel edge magnitude on greyscale-converted BGR pixels.
// ----------------------------------------------------------------------------
// Usage:
//  - req_*: one BGR pixel per beat in raster order; req_start_of_frame puts
//    the beat at row 0, column 0. Frames also wrap on their own after the
//    last pixel.
//  - rsp_*: one beat per interior pixel, carrying |Gx|+|Gy| saturated at 255
//    and the window center position; rsp_last_of_frame marks the last one.
//    Border pixels produce no beat.
//  - csr_*: frame_width (index 0) and frame_height (index 1), written while
//    the stream is idle. Values clamp to 3..1024.
//  - Throughput: one pixel per cycle sustained while rsp_ready stays high. The
//    result for a pixel passes stage A, the window queue, then the gradient
//    register; the result shows the window centered one row and one column
//    behind the pixel that completes it.
//  - A stalled receiver fills the four-entry window queue, after which
//    req_ready drops; nothing is lost.
//  - Reset clears counters, window and size registers (640x480); the line
//    stores are not cleared and need no clearing time.
// ----------------------------------------------------------------------------
module greyscale_sobel_edge_stream_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [gses_pkg::PIX_W-1:0] req_blue,
   input  logic [gses_pkg::PIX_W-1:0] req_green,
   input  logic [gses_pkg::PIX_W-1:0] req_red,
   input  logic                       req_start_of_frame,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [gses_pkg::PIX_W-1:0] rsp_magnitude,
   output logic [gses_pkg::POS_W-1:0] rsp_out_row,
   output logic [gses_pkg::POS_W-1:0] rsp_out_col,
   output logic                       rsp_last_of_frame,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [gses_pkg::DIM_W-1:0] csr_data
);
   import gses_pkg::*;

   logic q_push, q_full;
   window_type push_item, head;
   logic q_pop, q_not_empty;

   gses_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_blue           (req_blue),
      .req_green          (req_green),
      .req_red            (req_red),
      .req_start_of_frame (req_start_of_frame),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .q_push             (q_push),
      .q_full             (q_full),
      .q_item             (push_item)
   );

   gses_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (head)
   );

   gses_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_not_empty       (q_not_empty),
      .q_head            (head),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_magnitude     (rsp_magnitude),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule

### tb/greyscale_sobel_edge_stream_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greyscale_sobel_edge_stream_unit_tb
// Self-checking bench for the greyscale Sobel edge stream. A queue-fed driver
// sends BGR pixels. An in-bench luma and Sobel model predicts every edge beat,
// and a monitor checks the returned beats in order, field by field. Covers
// size clamping, frame wrap, shrinking the frame mid-stream, a long receiver
// hold-off and random idling on both channels.
// ----------------------------------------------------------------------------
module greyscale_sobel_edge_stream_unit_tb;
   import gses_pkg::*;

   localparam int HALF_PERIOD = 4;
   localparam int RESET_CYCLES = 8;
   localparam int SETTLE_CYCLES = 8;     // pipeline plus window queue, with margin
   localparam int HOLD_CYCLES = 64;
   localparam int QUIET_LIMIT = 2000;
   localparam int RANDOM_PIXELS = 100;
   localparam int MAX_LOG_LINES = 100;
   localparam int LINE_DEPTH = 1024;

   // Q16 luma weights
   localparam int LUMA_R = 19595;
   localparam int LUMA_G = 38470;
   localparam int LUMA_B = 7471;

   typedef enum int {TEX_NOISE, TEX_SMOOTH, TEX_STARK} texture_type;

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
      logic sof;
   } pixel_type;

   typedef struct packed {
      logic [PIX_W-1:0] magnitude;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic last;
   } edge_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [PIX_W-1:0] req_blue = '0;
   logic [PIX_W-1:0] req_green = '0;
   logic [PIX_W-1:0] req_red = '0;
   logic req_start_of_frame = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [PIX_W-1:0] rsp_magnitude;
   logic [POS_W-1:0] rsp_out_row;
   logic [POS_W-1:0] rsp_out_col;
   logic rsp_last_of_frame;
   logic csr_we = 1'b0;
   logic csr_index = 1'b0;
   logic [DIM_W-1:0] csr_data = '0;

   // bench copy of the block state
   logic [DIM_W-1:0] width_reg = 11'd640;
   logic [DIM_W-1:0] height_reg = 11'd480;
   bit [PIX_W-1:0] upper_line [LINE_DEPTH];
   bit [PIX_W-1:0] middle_line [LINE_DEPTH];
   bit [PIX_W-1:0] win_cols [6];
   int row_pos = 0;
   int col_pos = 0;

   pixel_type pixel_queue [$];
   edge_type pending_edges [$];
   int fail_count = 0;
   bit idle_on = 1'b0;
   int hold_requests = 0;
   int hold_served = 0;
   int send_gap = 0;
   int recv_stall = 0;
   int quiet_cycles = 0;

   greyscale_sobel_edge_stream_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_blue           (req_blue),
      .req_green          (req_green),
      .req_red            (req_red),
      .req_start_of_frame (req_start_of_frame),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_magnitude      (rsp_magnitude),
      .rsp_out_row        (rsp_out_row),
      .rsp_out_col        (rsp_out_col),
      .rsp_last_of_frame  (rsp_last_of_frame),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      forever #HALF_PERIOD clock = ~clock;
   end

   function automatic int eff_dim(input logic [DIM_W-1:0] value, input int max_dim);
      if (value < 3) return 3;
      if (int'(value) > max_dim) return max_dim;
      return int'(value);
   endfunction

   function automatic int draw_wait();
      return idle_on ? $urandom_range(0, 4) : 0;
   endfunction

   task automatic report_mismatch(input string msg);
      if (fail_count < MAX_LOG_LINES)
         $display("%0t ns: %s", $time, msg);
      fail_count++;
   endtask

   // One accepted pixel: update the window and line stores, queue the edge
   // beat it completes, if any.
   function automatic void sobel_step(input pixel_type pix);
      int w, h, r, c, grey, top, mid;
      int tl, ml, bl, tc, bc, gx, gy, mag;
      edge_type e;
      w = eff_dim(width_reg, int'(MAX_WIDTH));
      h = eff_dim(height_reg, int'(MAX_HEIGHT));
      grey = (LUMA_R * int'(pix.red) + LUMA_G * int'(pix.green)
              + LUMA_B * int'(pix.blue)) >> 16;
      if (pix.sof) begin
         r = 0;
         c = 0;
      end else begin
         r = row_pos;
         c = col_pos;
      end
      // counters left past a shrunken frame stick to the last row or column
      if (c >= w) c = w - 1;
      if (r >= h) r = h - 1;
      top = upper_line[c];
      mid = middle_line[c];
      if (r >= 2 && c >= 2) begin
         tl = win_cols[0];
         ml = win_cols[1];
         bl = win_cols[2];
         tc = win_cols[3];
         bc = win_cols[5];
         gx = (top + 2 * mid + grey) - (tl + 2 * ml + bl);
         gy = (tl + 2 * tc + top) - (bl + 2 * bc + grey);
         mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
         if (mag > 255) mag = 255;
         e.magnitude = PIX_W'(mag);
         e.row = POS_W'(r - 1);
         e.col = POS_W'(c - 1);
         e.last = (r == h - 1) && (c == w - 1);
         pending_edges.push_back(e);
      end
      upper_line[c] = PIX_W'(mid);
      middle_line[c] = PIX_W'(grey);
      win_cols[0] = win_cols[3];
      win_cols[1] = win_cols[4];
      win_cols[2] = win_cols[5];
      win_cols[3] = PIX_W'(top);
      win_cols[4] = PIX_W'(mid);
      win_cols[5] = PIX_W'(grey);
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      row_pos = r;
      col_pos = c;
   endfunction

   function automatic pixel_type make_pixel(input texture_type tex, input int base,
                                            input bit sof);
      pixel_type p;
      case (tex)
         TEX_SMOOTH: begin
            p.blue = PIX_W'(base + $urandom_range(0, 7));
            p.green = PIX_W'(base + $urandom_range(0, 7));
            p.red = PIX_W'(base + $urandom_range(0, 7));
         end
         TEX_STARK: begin
            p.blue = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            p.green = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            p.red = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
         end
         default: begin
            p.blue = PIX_W'($urandom_range(0, 255));
            p.green = PIX_W'($urandom_range(0, 255));
            p.red = PIX_W'($urandom_range(0, 255));
         end
      endcase
      p.sof = sof;
      return p;
   endfunction

   // stray start-of-frame marks restart the frame at a random point
   task automatic push_run(input int count, input texture_type tex, input int base,
                           input bit sof_first, input bit stray);
      for (int i = 0; i < count; i++)
         pixel_queue.push_back(make_pixel(tex, base, (i == 0) ? sof_first
                                          : (stray && $urandom_range(0, 39) == 0)));
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (pixel_queue.size() != 0 || req_valid || pending_edges.size() != 0)
         @(negedge clock);
      // border pixels give no beat; let the pipeline empty
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input int value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= DIM_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_FRAME_WIDTH)
         width_reg = DIM_W'(value);
      else
         height_reg = DIM_W'(value);
      @(negedge clock);
   endtask

   function automatic int pick_dim();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 2);
         1: return 3;
         default: return $urandom_range(4, 12);
      endcase
   endfunction

   // pixel driver
   always @(posedge clock) begin : drive_pixels
      pixel_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready)
            sobel_step(pixel_type'{req_blue, req_green, req_red, req_start_of_frame});
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pixel_queue.size() != 0) begin
               nxt = pixel_queue.pop_front();
               req_valid <= 1'b1;
               req_blue <= nxt.blue;
               req_green <= nxt.green;
               req_red <= nxt.red;
               req_start_of_frame <= nxt.sof;
               send_gap = draw_wait();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // edge beat monitor and receiver
   always @(posedge clock) begin : check_edges
      edge_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_edges.size() == 0) begin
               report_mismatch($sformatf("edge beat row %0d col %0d with none pending",
                                         rsp_out_row, rsp_out_col));
            end else begin
               want = pending_edges.pop_front();
               if (rsp_magnitude !== want.magnitude)
                  report_mismatch($sformatf("magnitude %0d, expected %0d at row %0d col %0d",
                                            rsp_magnitude, want.magnitude, want.row, want.col));
               if (rsp_out_row !== want.row)
                  report_mismatch($sformatf("out_row %0d, expected %0d",
                                            rsp_out_row, want.row));
               if (rsp_out_col !== want.col)
                  report_mismatch($sformatf("out_col %0d, expected %0d",
                                            rsp_out_col, want.col));
               if (rsp_last_of_frame !== want.last)
                  report_mismatch($sformatf("last_of_frame %0b, expected %0b at row %0d col %0d",
                                            rsp_last_of_frame, want.last, want.row, want.col));
            end
            recv_stall = draw_wait();
         end
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            recv_stall = HOLD_CYCLES;
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("greyscale_sobel_edge_stream_unit: mismatch");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int r, c, w_eff, h_eff, n, frames, base, random_pixels;
      texture_type tex;
      pixel_type p;
      random_pixels = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: 4x3 frames with saturating and flat edges
      write_reg(REG_FRAME_WIDTH, 4);
      write_reg(REG_FRAME_HEIGHT, 3);
      for (int i = 0; i < 12; i++) begin
         r = i / 4;
         c = i % 4;
         p = pixel_type'{8'h00, 8'h00, 8'h00, i == 0};
         if (r == 0) begin
            p.blue = 8'hFF;
            p.green = 8'hFF;
            p.red = 8'hFF;
         end else if (r == 1) begin
            p.blue = (c == 0) ? 8'hFF : 8'h00;
            p.green = (c == 1) ? 8'hFF : 8'h00;
            p.red = (c == 2) ? 8'hFF : 8'h00;
         end
         pixel_queue.push_back(p);
      end
      // second frame starts by wrapping, no start-of-frame mark
      for (int i = 0; i < 12; i++) begin
         c = i % 4;
         p.blue = (c % 2 == 0) ? 8'hFF : 8'h00;
         p.green = p.blue;
         p.red = p.blue;
         p.sof = 1'b0;
         pixel_queue.push_back(p);
      end

      // receiver holds off while the sender streams, filling the block
      wait_idle();
      write_reg(REG_FRAME_WIDTH, 5);
      write_reg(REG_FRAME_HEIGHT, 8);
      idle_on = 1'b0;
      hold_requests++;
      push_run(80, TEX_NOISE, 0, 1'b1, 1'b0);

      // width shrinks mid-frame: column 6 of row 2 becomes column 3
      wait_idle();
      idle_on = 1'b1;
      write_reg(REG_FRAME_WIDTH, 8);
      write_reg(REG_FRAME_HEIGHT, 6);
      push_run(22, TEX_SMOOTH, $urandom_range(0, 248), 1'b1, 1'b0);
      wait_idle();
      write_reg(REG_FRAME_WIDTH, 4);
      push_run(37, TEX_NOISE, 0, 1'b0, 1'b0);

      // tallest frame, then a height shrink from row 14 down to row 4
      wait_idle();
      write_reg(REG_FRAME_WIDTH, 3);
      write_reg(REG_FRAME_HEIGHT, 1025);
      push_run(42, TEX_SMOOTH, $urandom_range(0, 248), 1'b1, 1'b0);
      wait_idle();
      write_reg(REG_FRAME_HEIGHT, 5);
      push_run(18, TEX_STARK, 0, 1'b0, 1'b0);

      // over-range width and under-range height, then column 40 of row 0
      // becomes column 2 of a three-wide frame
      wait_idle();
      write_reg(REG_FRAME_WIDTH, 2047);
      write_reg(REG_FRAME_HEIGHT, 0);
      push_run(40, TEX_NOISE, 0, 1'b1, 1'b0);
      wait_idle();
      write_reg(REG_FRAME_WIDTH, 3);
      push_run(7, TEX_STARK, 0, 1'b0, 1'b0);

      // random small frames
      while (random_pixels < RANDOM_PIXELS) begin
         wait_idle();
         write_reg(REG_FRAME_WIDTH, pick_dim());
         write_reg(REG_FRAME_HEIGHT, pick_dim());
         w_eff = eff_dim(width_reg, int'(MAX_WIDTH));
         h_eff = eff_dim(height_reg, int'(MAX_HEIGHT));
         idle_on = ($urandom_range(0, 3) != 0);
         tex = texture_type'($urandom_range(0, 2));
         base = $urandom_range(0, 248);
         frames = $urandom_range(1, 3);
         for (int k = 0; k < frames; k++) begin
            n = w_eff * h_eff;
            // now and then a frame is cut short
            if ($urandom_range(0, 5) == 0) n = $urandom_range(1, n - 1);
            push_run(n, tex, base, k == 0 || $urandom_range(0, 1) == 1, 1'b1);
            random_pixels += n;
         end
      end

      wait_idle();
      if (fail_count == 0)
         $display("greyscale_sobel_edge_stream_unit: match");
      else
         $display("greyscale_sobel_edge_stream_unit: mismatch");
      $finish;
   end

endmodule
